/* src/nfq_pkg.sv */
// ----------------------------------------------------------------------------
// nfq_pkg
// Shared types and fixed constants of the notification frame queue.
// ----------------------------------------------------------------------------
package nfq_pkg;

    // Operation codes carried on s_tuser
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_PULL = 1'b1;

    // Frame header: opcode, handle low byte, handle high byte
    localparam logic [7:0] HDR_OPCODE = 8'h1B;
    localparam int         HDR_LEN    = 3;
    localparam int         HDR_POS_OP = 0;
    localparam int         HDR_POS_LO = 1;

    // Fixed field widths
    localparam int ROOM_W      = 10;
    localparam int PENDING_W   = 3;
    localparam int DROP_W      = 32;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 48;

    // Controller states
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_LOAD
    } nfq_state_t;

    // Controller to datapath
    typedef struct packed {
        logic exec;   // request accepted this cycle, update state
        logic load;   // fill the output register
    } nfq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_busy;   // output register holds an untaken result
    } nfq_status_t;

endpackage

/* src/nfq_ram.sv */
// ----------------------------------------------------------------------------
// nfq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module nfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 992
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/nfq_ctrl.sv */
// ----------------------------------------------------------------------------
// nfq_ctrl
// Request sequencer: accepts one request in ST_IDLE, then loads its result in
// ST_LOAD once the frame store read data is back.
// ----------------------------------------------------------------------------
module nfq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 m_tready,
    input  nfq_pkg::nfq_status_t status,
    output logic                 s_tready,
    output nfq_pkg::nfq_cmd_t    cmd
);

    nfq_pkg::nfq_state_t state_reg;
    nfq_pkg::nfq_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nfq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd.exec   = 1'b0;
        cmd.load   = 1'b0;
        unique case (state_reg)
            nfq_pkg::ST_IDLE:
            begin
                // output register must be empty or draining this cycle
                s_tready = !status.out_busy || m_tready;
                cmd.exec = s_tvalid && s_tready;
                if (cmd.exec)
                begin
                    state_next = nfq_pkg::ST_LOAD;
                end
            end
            nfq_pkg::ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = nfq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = nfq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* src/nfq_datapath.sv */
// ----------------------------------------------------------------------------
// nfq_datapath
// Frame ring state, frame store, header insertion and the output register.
// ----------------------------------------------------------------------------
module nfq_datapath #(
    parameter int SLOTS     = 4,
    parameter int FRAME_MAX = 248
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  nfq_pkg::nfq_cmd_t              cmd,
    output nfq_pkg::nfq_status_t           status,
    // request fields
    input  logic                           operation,
    input  logic [7:0]                     data_byte,
    input  logic                           frame_end,
    input  logic                           notify_enabled,
    input  logic [nfq_pkg::ROOM_W-1:0]     room,
    // handle register write
    input  logic                           cfg_valid,
    input  logic [15:0]                    cfg_data,
    // result
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic                           out_valid,
    output logic [7:0]                     out_byte,
    output logic                           out_last,
    output logic [nfq_pkg::PENDING_W-1:0]  frames_pending,
    output logic [nfq_pkg::DROP_W-1:0]     drop_count
);

    localparam int IW   = $clog2(SLOTS);
    localparam int HW   = $clog2(SLOTS + 1);
    localparam int LW   = $clog2(FRAME_MAX + 1);
    localparam int CW   = $clog2(FRAME_MAX + nfq_pkg::HDR_LEN);
    localparam int NW   = $clog2(FRAME_MAX + nfq_pkg::HDR_LEN + 1);
    localparam int SUMW = (NW > nfq_pkg::ROOM_W) ? NW : nfq_pkg::ROOM_W;
    localparam int DEPTH = SLOTS * FRAME_MAX;
    localparam int AW   = $clog2(DEPTH);

    // ring state
    logic [IW-1:0]             head_reg, head_next;
    logic [IW-1:0]             tail_reg, tail_next;
    logic [HW-1:0]             held_reg, held_next;
    logic [nfq_pkg::DROP_W-1:0] drop_reg, drop_next;
    logic [LW-1:0]             wlen_reg, wlen_next;
    logic                      wdisc_reg, wdisc_next;
    logic [CW-1:0]             cursor_reg, cursor_next;
    logic                      active_reg, active_next;
    logic [15:0]               handle_reg;
    logic [LW-1:0]             len_mem [SLOTS];
    logic                      len_we;

    // result latched at accept, used when the output register is loaded
    logic                      res_valid_reg, res_valid_next;
    logic                      res_ram_reg, res_ram_next;
    logic [7:0]                res_byte_reg, res_byte_next;
    logic                      res_last_reg, res_last_next;

    // output register
    logic                      m_tvalid_reg;
    logic                      out_valid_reg;
    logic [7:0]                out_byte_reg;
    logic                      out_last_reg;
    logic [nfq_pkg::PENDING_W-1:0] pend_reg;
    logic [nfq_pkg::DROP_W-1:0] drop_out_reg;

    // frame store port
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic                      ram_re;
    logic [AW-1:0]             ram_raddr;
    logic [7:0]                ram_rdata;

    // helpers
    logic                      push_disc;
    logic [LW-1:0]             wlen_inc;
    logic [LW-1:0]             head_len;
    logic [SUMW-1:0]           need;
    logic                      start_ok;
    logic [CW-1:0]             cur;
    logic [SUMW-1:0]           cur_inc;
    logic                      is_last;
    logic [LW-1:0]             pay_off;
    logic [IW-1:0]             head_inc;
    logic [IW-1:0]             tail_inc;
    logic [HW+2:0]             held_ext;

    nfq_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (data_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared decode
    always_comb
    begin
        head_inc  = (head_reg == IW'(SLOTS - 1)) ? '0 : head_reg + 1'b1;
        tail_inc  = (tail_reg == IW'(SLOTS - 1)) ? '0 : tail_reg + 1'b1;
        push_disc = wdisc_reg
                    || ((wlen_reg == '0) && (held_reg >= HW'(SLOTS)))
                    || (wlen_reg >= LW'(FRAME_MAX));
        wlen_inc  = wlen_reg + 1'b1;
        head_len  = len_mem[head_reg];
        need      = SUMW'(nfq_pkg::HDR_LEN) + SUMW'(head_len);
        start_ok  = active_reg
                    || ((held_reg != '0) && notify_enabled && (need <= SUMW'(room)));
        cur       = active_reg ? cursor_reg : '0;
        cur_inc   = SUMW'(cur) + 1'b1;
        is_last   = (cur_inc >= need);
        pay_off   = LW'(cur - CW'(nfq_pkg::HDR_LEN));
        ram_waddr = AW'(tail_reg) * AW'(FRAME_MAX) + AW'(wlen_reg);
        ram_raddr = AW'(head_reg) * AW'(FRAME_MAX) + AW'(pay_off);
    end

    // Request execution
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        held_next      = held_reg;
        drop_next      = drop_reg;
        wlen_next      = wlen_reg;
        wdisc_next     = wdisc_reg;
        cursor_next    = cursor_reg;
        active_next    = active_reg;
        len_we         = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        res_valid_next = res_valid_reg;
        res_ram_next   = res_ram_reg;
        res_byte_next  = res_byte_reg;
        res_last_next  = res_last_reg;
        if (cmd.exec)
        begin
            res_valid_next = 1'b0;
            res_ram_next   = 1'b0;
            res_byte_next  = '0;
            res_last_next  = 1'b0;
            if (operation == nfq_pkg::OP_PUSH)
            begin
                // store the byte unless the frame is being thrown away
                if (!push_disc)
                begin
                    ram_we    = 1'b1;
                    wlen_next = wlen_inc;
                end
                else if (wlen_reg == '0)
                begin
                    wlen_next = LW'(1);
                end
                wdisc_next = push_disc;
                if (frame_end)
                begin
                    if (push_disc)
                    begin
                        drop_next = drop_reg + 1'b1;
                    end
                    else
                    begin
                        len_we    = 1'b1;
                        tail_next = tail_inc;
                        held_next = held_reg + 1'b1;
                    end
                    wlen_next  = '0;
                    wdisc_next = 1'b0;
                end
            end
            else if (start_ok)
            begin
                // header bytes from opcode and handle, payload from the store
                res_valid_next = 1'b1;
                res_last_next  = is_last;
                if (cur == CW'(nfq_pkg::HDR_POS_OP))
                begin
                    res_byte_next = nfq_pkg::HDR_OPCODE;
                end
                else if (cur == CW'(nfq_pkg::HDR_POS_LO))
                begin
                    res_byte_next = handle_reg[7:0];
                end
                else if (cur == CW'(nfq_pkg::HDR_LEN - 1))
                begin
                    res_byte_next = handle_reg[15:8];
                end
                else
                begin
                    res_ram_next = 1'b1;
                    ram_re       = 1'b1;
                end
                if (is_last)
                begin
                    head_next   = head_inc;
                    held_next   = held_reg - 1'b1;
                    active_next = 1'b0;
                    cursor_next = '0;
                end
                else
                begin
                    active_next = 1'b1;
                    cursor_next = CW'(cur_inc);
                end
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            held_reg      <= '0;
            drop_reg      <= '0;
            wlen_reg      <= '0;
            wdisc_reg     <= 1'b0;
            cursor_reg    <= '0;
            active_reg    <= 1'b0;
            handle_reg    <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            held_reg   <= held_next;
            drop_reg   <= drop_next;
            wlen_reg   <= wlen_next;
            wdisc_reg  <= wdisc_next;
            cursor_reg <= cursor_next;
            active_reg <= active_next;
            if (cfg_valid)
            begin
                handle_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    assign held_ext = {3'b000, held_reg};

    always_ff @(posedge clk)
    begin
        res_valid_reg <= res_valid_next;
        res_ram_reg   <= res_ram_next;
        res_byte_reg  <= res_byte_next;
        res_last_reg  <= res_last_next;
        if (len_we)
        begin
            len_mem[tail_reg] <= wlen_inc;
        end
        if (cmd.load)
        begin
            out_valid_reg <= res_valid_reg;
            out_byte_reg  <= res_ram_reg ? ram_rdata : res_byte_reg;
            out_last_reg  <= res_last_reg;
            pend_reg      <= held_ext[nfq_pkg::PENDING_W-1:0];
            drop_out_reg  <= drop_reg;
        end
    end

    assign status.out_busy = m_tvalid_reg;
    assign m_tvalid        = m_tvalid_reg;
    assign out_valid       = out_valid_reg;
    assign out_byte        = out_byte_reg;
    assign out_last        = out_last_reg;
    assign frames_pending  = pend_reg;
    assign drop_count      = drop_out_reg;

endmodule

/* src/notify_frame_queue.sv */
// ----------------------------------------------------------------------------
// notify_frame_queue
// Ring of frame slots for outgoing notifications with header insertion.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries requests: s_tuser 0 pushes the byte in s_tdata, s_tlast marks
//   the last byte of a frame; s_tuser 1 pulls one output byte. A pull starts a
//   frame only if one is held, notifications are enabled and header plus
//   payload fit in room; the frame goes out as opcode 0x1B, the handle low and
//   high bytes, then the payload.
//   m_* returns exactly one result per request: m_tuser says whether the byte
//   is a frame byte, m_tlast marks its last byte; pending frame count and the
//   wrapping drop counter ride along in m_tdata.
//   cfg_* writes the 16-bit attribute handle; it is always ready.
//   Timing: m_tvalid is registered; an accepted request moves the
//   controller to ST_LOAD, which loads the output register and raises
//   m_tvalid. Owing to the registered read of the frame store memory, no new
//   request is taken until the controller is back in ST_IDLE. A new request
//   is taken while the previous result is being taken in the same cycle.
//   Reset clears the ring pointers, counters, handle and output valid; the
//   frame store itself needs no clearing. A stalled m_tready holds the result
//   and blocks s_tready until it is taken.
// ----------------------------------------------------------------------------
module notify_frame_queue #(
    parameter int SLOTS     = 4,
    parameter int FRAME_MAX = 248
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // requests
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata: data_byte[7:0], notify_enabled[8], room[18:9]
    input  logic [nfq_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tlast,  // frame_end
    input  logic                               s_tuser,  // operation
    // results
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata: out_byte[7:0], frames_pending[10:8], drop_count[42:11]
    output logic [nfq_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                               m_tlast,  // out_last
    output logic                               m_tuser,  // out_valid
    // handle register
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [15:0]                        cfg_data
);

    nfq_pkg::nfq_cmd_t    cmd;
    nfq_pkg::nfq_status_t status;

    logic [7:0]                       out_byte;
    logic [nfq_pkg::PENDING_W-1:0]    frames_pending;
    logic [nfq_pkg::DROP_W-1:0]       drop_count;

    assign cfg_ready = 1'b1;

    nfq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    nfq_datapath #(
        .SLOTS     (SLOTS),
        .FRAME_MAX (FRAME_MAX)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .operation      (s_tuser),
        .data_byte      (s_tdata[7:0]),
        .frame_end      (s_tlast),
        .notify_enabled (s_tdata[8]),
        .room           (s_tdata[18:9]),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .out_valid      (m_tuser),
        .out_byte       (out_byte),
        .out_last       (m_tlast),
        .frames_pending (frames_pending),
        .drop_count     (drop_count)
    );

    // result packing, padded to whole bytes
    assign m_tdata = {5'b00000, drop_count, frames_pending, out_byte};

endmodule

/* test/tb_notify_frame_queue.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_notify_frame_queue
// Self-checking bench for the notification frame queue. A queue of pending
// requests feeds a bursty driver. A behavioural copy of the slot ring predicts
// every result at acceptance, and a monitor compares each result field by
// field against the oldest prediction. The receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_notify_frame_queue;

    localparam int SLOTS      = 4;
    localparam int FRAME_MAX  = 248;
    localparam int IDLE_LIMIT = 2000;
    localparam int MAX_SHOWN  = 10;

    typedef logic [nfq_pkg::ROOM_W-1:0]    room_t;
    typedef logic [nfq_pkg::PENDING_W-1:0] pend_t;

    // One request as the predictor sees it
    typedef struct packed {
        logic                op;
        logic [7:0]          data;
        logic                frame_end;
        logic                enabled;
        room_t               room;
    } queue_req_t;

    // One result
    typedef struct packed {
        logic                        valid_byte;
        logic [7:0]                  frame_byte;
        logic                        last_byte;
        pend_t                       pending;
        logic [nfq_pkg::DROP_W-1:0]  drops;
    } queue_out_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    // s_tdata: data_byte[7:0], notify_enabled[8], room[18:9]
    logic [nfq_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic                            s_tlast = 1'b0;             // frame_end
    logic                            s_tuser = nfq_pkg::OP_PUSH; // operation
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // m_tdata: out_byte[7:0], frames_pending[10:8], drop_count[42:11]
    logic [nfq_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            m_tlast;        // out_last
    logic                            m_tuser;        // out_valid
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [15:0]                     cfg_data = '0;

    // Stimulus and expectation stores
    queue_req_t  pending_q[$];
    queue_out_t  reply_q[$];
    logic [15:0] handle_q[$];
    queue_req_t  req_now;

    // Predicted ring state
    logic [7:0]  ring_mem [SLOTS][FRAME_MAX];
    int unsigned ring_len [SLOTS];
    int unsigned head_idx = 0;
    int unsigned tail_idx = 0;
    int unsigned held_cnt = 0;
    logic [31:0] drop_cnt = '0;
    int unsigned fill_len = 0;
    bit          fill_discard = 1'b0;
    int unsigned send_pos = 0;
    bit          sending = 1'b0;
    logic [15:0] handle_now = '0;

    // Sender pacing, receiver pattern, tallies
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    logic [8:0]  rx_tick = '0;
    int unsigned idle_cycles = 0;
    int unsigned mismatches = 0;
    int unsigned push_cnt = 0;
    int unsigned pull_cnt = 0;
    int unsigned sent_cnt = 0;
    int unsigned handle_writes = 0;
    queue_out_t  got;
    queue_out_t  want;

    notify_frame_queue #(
        .SLOTS     (SLOTS),
        .FRAME_MAX (FRAME_MAX)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Advance the ring by one request and return the result it should give
    function automatic queue_out_t advance_queue(input queue_req_t r);
        queue_out_t  res;
        int unsigned h;
        res = '0;
        h = head_idx;
        if (r.op == nfq_pkg::OP_PUSH)
        begin
            push_cnt++;
            if (fill_len == 0 && held_cnt >= SLOTS)
                fill_discard = 1'b1;
            if (fill_len >= FRAME_MAX)
                fill_discard = 1'b1;
            if (!fill_discard)
            begin
                ring_mem[tail_idx][fill_len] = r.data;
                fill_len++;
            end
            // a discarded frame still counts as started
            if (fill_len == 0)
                fill_len = 1;
            if (r.frame_end)
            begin
                if (fill_discard)
                    drop_cnt = drop_cnt + 1;
                else
                begin
                    ring_len[tail_idx] = fill_len;
                    tail_idx = (tail_idx + 1) % SLOTS;
                    held_cnt++;
                end
                fill_len = 0;
                fill_discard = 1'b0;
            end
        end
        else
        begin
            pull_cnt++;
            // start condition only matters at the first header byte
            if (!sending && held_cnt != 0 && r.enabled
                && nfq_pkg::HDR_LEN + ring_len[h] <= r.room)
            begin
                sending = 1'b1;
                send_pos = 0;
            end
            if (sending)
            begin
                res.valid_byte = 1'b1;
                if (send_pos == nfq_pkg::HDR_POS_OP)
                    res.frame_byte = nfq_pkg::HDR_OPCODE;
                else if (send_pos == nfq_pkg::HDR_POS_LO)
                    res.frame_byte = handle_now[7:0];
                else if (send_pos == nfq_pkg::HDR_LEN - 1)
                    res.frame_byte = handle_now[15:8];
                else
                    res.frame_byte = ring_mem[h][(send_pos - nfq_pkg::HDR_LEN) % FRAME_MAX];
                if (send_pos + 1 >= nfq_pkg::HDR_LEN + ring_len[h])
                begin
                    res.last_byte = 1'b1;
                    head_idx = (head_idx + 1) % SLOTS;
                    held_cnt--;
                    sending = 1'b0;
                    send_pos = 0;
                    sent_cnt++;
                end
                else
                    send_pos++;
            end
        end
        res.pending = pend_t'(held_cnt);
        res.drops = drop_cnt;
        return res;
    endfunction

    // Driver: handle writes and requests, bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tlast <= 1'b0;
            s_tuser <= nfq_pkg::OP_PUSH;
            cfg_valid <= 1'b0;
            cfg_data <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            // handle register
            if (cfg_valid && cfg_ready)
            begin
                handle_now = cfg_data;
                handle_writes++;
            end
            if ((!cfg_valid || cfg_ready) && handle_q.size() != 0)
            begin
                cfg_valid <= 1'b1;
                cfg_data <= handle_q.pop_front();
            end
            else if (cfg_valid && cfg_ready)
                cfg_valid <= 1'b0;

            // predict the request taken at this edge before loading the next
            if (s_tvalid && s_tready)
                reply_q.push_back(advance_queue(req_now));
            if (!s_tvalid || s_tready)
            begin
                if (gap_left != 0 || pending_q.size() == 0)
                begin
                    s_tvalid <= 1'b0;
                    if (gap_left != 0)
                        gap_left--;
                end
                else
                begin
                    req_now = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {5'b0, req_now.room, req_now.enabled, req_now.data};
                    s_tlast <= req_now.frame_end;
                    s_tuser <= req_now.op;
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 16);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // Receiver stall pattern: steady, random, sparse, mostly ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_tick <= '0;
        end
        else
        begin
            rx_tick <= rx_tick + 1'b1;
            unique case (rx_tick[8:7])
                2'd0:    m_tready <= 1'b1;
                2'd1:    m_tready <= ($urandom_range(0, 1) == 1);
                2'd2:    m_tready <= (rx_tick[1:0] == 2'd3);
                default: m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Monitor: compare each result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got.valid_byte = m_tuser;
            got.frame_byte = m_tdata[7:0];
            got.last_byte = m_tlast;
            got.pending = m_tdata[10:8];
            got.drops = m_tdata[42:11];
            if (reply_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("%0t: unexpected result valid=%0b byte=%02h last=%0b pend=%0d drops=%0d",
                             $realtime, got.valid_byte, got.frame_byte, got.last_byte,
                             got.pending, got.drops);
            end
            else
            begin
                want = reply_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                    begin
                        $display("%0t: mismatch exp valid=%0b byte=%02h last=%0b pend=%0d drops=%0d",
                                 $realtime, want.valid_byte, want.frame_byte, want.last_byte,
                                 want.pending, want.drops);
                        $display("%0t:          got valid=%0b byte=%02h last=%0b pend=%0d drops=%0d",
                                 $realtime, got.valid_byte, got.frame_byte, got.last_byte,
                                 got.pending, got.drops);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no handshake of any kind
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic add_push(input logic [7:0] d, input logic fin);
        queue_req_t r;
        r = '0;
        r.op = nfq_pkg::OP_PUSH;
        r.data = d;
        r.frame_end = fin;
        r.enabled = 1'($urandom_range(0, 1));
        r.room = room_t'($urandom_range(0, 1023));
        pending_q.push_back(r);
    endtask

    task automatic add_pull(input logic en, input room_t rm);
        queue_req_t r;
        r = '0;
        r.op = nfq_pkg::OP_PULL;
        r.data = 8'($urandom_range(0, 255));
        r.frame_end = 1'($urandom_range(0, 1));
        r.enabled = en;
        r.room = rm;
        pending_q.push_back(r);
    endtask

    // Wait until every request is taken and every result has come back
    task automatic wait_drain();
        do
            @(negedge clk);
        while (pending_q.size() != 0 || s_tvalid || reply_q.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    task automatic set_handle(input logic [15:0] v);
        handle_q.push_back(v);
        do
            @(negedge clk);
        while (handle_q.size() != 0 || cfg_valid);
    endtask

    function automatic room_t pick_room();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return 10'd1023;
        else if (sel < 70)
            return room_t'($urandom_range(0, 24));
        return room_t'($urandom_range(0, 1023));
    endfunction

    function automatic int unsigned pick_frame_len();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return $urandom_range(1, 8);
        else if (sel < 95)
            return $urandom_range(9, 40);
        return $urandom_range(41, 120);
    endfunction

    // Mostly whole frames and runs of pulls, some stray requests
    task automatic add_random_traffic(input int unsigned target);
        int unsigned n;
        int unsigned sel;
        int unsigned len;
        int unsigned i;
        n = 0;
        while (n < target)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 45)
            begin
                len = pick_frame_len();
                for (i = 0; i < len; i++)
                    add_push(8'($urandom_range(0, 255)), i == len - 1);
                n += len;
            end
            else if (sel < 88)
            begin
                len = $urandom_range(1, 12);
                for (i = 0; i < len; i++)
                    add_pull($urandom_range(0, 9) != 0, pick_room());
                n += len;
            end
            else if (sel < 94)
            begin
                add_push(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                n++;
            end
            else
            begin
                add_pull(1'($urandom_range(0, 1)), room_t'($urandom_range(0, 1023)));
                n++;
            end
        end
    endtask

    // Close any open frame and empty the ring
    task automatic flush_ring();
        int unsigned i;
        if (fill_len != 0)
        begin
            add_push(8'h00, 1'b1);
            wait_drain();
        end
        while (held_cnt != 0 || sending)
        begin
            for (i = 0; i < 16; i++)
                add_pull(1'b1, 10'd1023);
            wait_drain();
        end
    endtask

    // A frame one byte too long, then a short frame sent at an exact fit
    task automatic add_long_frames();
        int unsigned i;
        for (i = 0; i <= FRAME_MAX; i++)
            add_push(8'($urandom_range(0, 255)), i == FRAME_MAX);
        add_push(8'h3C, 1'b1);
        for (i = 0; i < nfq_pkg::HDR_LEN + 1; i++)
            add_pull(1'b1, room_t'(nfq_pkg::HDR_LEN + 1));
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: refusals, exact fit, continuation, full ring
        set_handle(16'hFFFF);
        add_pull(1'b1, 10'd1023);           // nothing held
        add_push(8'h00, 1'b0);
        add_push(8'hFF, 1'b1);
        add_pull(1'b0, 10'd1023);           // notifications off
        add_pull(1'b1, 10'd4);              // one byte short of room
        add_pull(1'b1, 10'd5);              // exact fit, opcode
        add_pull(1'b0, 10'd0);              // rest of frame ignores enable and room
        add_pull(1'b0, 10'd0);
        add_pull(1'b1, 10'd0);
        add_pull(1'b1, 10'd0);
        add_push(8'h55, 1'b1);
        add_push(8'hAA, 1'b1);
        add_push(8'h01, 1'b1);
        add_push(8'h80, 1'b1);
        add_push(8'h12, 1'b0);              // ring full at first byte
        add_pull(1'b1, 10'd1023);           // frees a slot mid-frame
        add_pull(1'b1, 10'd1023);
        add_pull(1'b1, 10'd1023);
        add_pull(1'b1, 10'd1023);
        add_push(8'h34, 1'b1);              // still dropped
        add_push(8'h7E, 1'b1);
        wait_drain();

        set_handle(16'h0000);
        add_random_traffic(60);
        wait_drain();

        set_handle(16'($urandom_range(0, 16'hFFFF)));
        flush_ring();
        add_long_frames();
        wait_drain();

        set_handle(16'h8001);
        add_random_traffic(30);
        wait_drain();
        repeat (8) @(negedge clk);

        $display("Run covered %0d pushes and %0d pulls, %0d frames sent, %0d frames dropped",
                 push_cnt, pull_cnt, sent_cnt, drop_cnt);
        $display("Handle written %0d times, %0d mismatches", handle_writes, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* notify_frame_queue.f */
src/nfq_pkg.sv
src/nfq_ram.sv
src/nfq_ctrl.sv
src/nfq_datapath.sv
src/notify_frame_queue.sv
test/tb_notify_frame_queue.sv
